FILE: hw/rtl/ito_pkg.sv
// ito_pkg: shared types and constants for the incremental topological order unit
// no dependencies; imported by tpo rows memory, core and top level
`default_nettype none

package ito_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int ID_WIDTH_DEF  = 32;
    localparam int NLIM_W        = 7;
    localparam int ELIM_W        = 12;
    localparam int CFG_DATA_W    = 12;
    localparam int OUT_ID_W      = 32;
    localparam int VIS_W         = 8;

    localparam logic CFG_NODE_LIMIT = 1'b0;
    localparam logic CFG_EDGE_LIMIT = 1'b1;

    localparam logic REQ_ADD_NODE = 1'b0;

    typedef enum logic [2:0] {
        ST_OK,
        ST_DUP,
        ST_CYCLE,
        ST_NODE_LIM,
        ST_EDGE_LIM,
        ST_EXISTS,
        ST_FULL
    } status_t;

    typedef struct packed {
        logic [NLIM_W-1:0] node_limit;
        logic [ELIM_W-1:0] edge_limit;
    } cfg_t;

    typedef struct packed {
        status_t               status;
        logic                  reordered;
        logic [VIS_W-1:0]      visited;
        logic [OUT_ID_W-1:0]   path_id;
        logic                  last;
    } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ito_rowmem.sv
// ito_rowmem: adjacency row store, one row per node, registered read
// rows read as zero until first written; uses ito_pkg
`default_nettype none

module ito_rowmem
    import ito_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [IW-1:0]        ra,
    output logic      [MAX_NODES-1:0] q,
    input  wire logic                 we,
    input  wire logic [IW-1:0]        wa,
    input  wire logic [MAX_NODES-1:0] wd
);

    logic [MAX_NODES-1:0] mem [MAX_NODES];
    logic [MAX_NODES-1:0] valid_reg;
    logic [MAX_NODES-1:0] mq_reg;
    logic                 vq_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        mq_reg <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vq_reg    <= 1'b0;
        end
        else
        begin
            vq_reg <= valid_reg[ra];
            if (we)
            begin
                valid_reg[wa] <= 1'b1;
            end
        end
    end

    assign q = vq_reg ? mq_reg : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/ito_core.sv
// ito_core: sequencer for node/edge requests, window search, cycle report and reorder
// depends on ito_pkg and ito_rowmem
`default_nettype none

module ito_core
    import ito_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int ID_WIDTH  = ID_WIDTH_DEF
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               req_type,
    input  wire logic signed [31:0] src_id,
    input  wire logic signed [31:0] dst_id,
    input  wire cfg_t               cfg,
    output logic                    busy,
    output logic                    res_valid,
    output res_t                    res
);

    localparam int N  = MAX_NODES;
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int CW = $clog2(N + 1);
    localparam int KW = (ID_WIDTH < 32) ? ID_WIDTH : 32;
    localparam int LW = CW + 8;
    localparam int VW = (CW + 1 > 9) ? CW + 1 : 9;

    typedef enum logic [5:0] {
        S_IDLE, S_LOOK, S_LOOKC, S_DECIDE, S_DUP, S_LIM, S_INTV,
        S_PU, S_PV, S_PCMP, S_WIN, S_WINC,
        S_SINIT, S_POP, S_POPW, S_ROW, S_PUSH, S_AFTER,
        S_CH, S_CHW, S_OUTC, S_OUTCW, S_OUTCE, S_BK, S_BKW, S_BKE,
        S_RA1, S_RA2, S_RB1, S_RB2, S_RC1, S_RC2, S_ADD0, S_ADD1
    } state_t;

    function automatic logic [IW-1:0] lowest(input logic [N-1:0] m);
        logic [IW-1:0] r;
        r = '0;
        for (int j = N - 1; j >= 0; j--)
        begin
            if (m[j])
            begin
                r = IW'(j);
            end
        end
        return r;
    endfunction

    function automatic res_t mk(input status_t st, input logic ro,
                                input logic [VIS_W-1:0] vis,
                                input logic [KW-1:0] pid, input logic lst);
        res_t r;
        r.status    = st;
        r.reordered = ro;
        r.visited   = vis;
        r.path_id   = OUT_ID_W'(pid);
        r.last      = lst;
        return r;
    endfunction

    state_t state_reg, state_next;
    logic rt_reg, rt_next;
    logic [KW-1:0] a_reg, a_next, b_reg, b_next;
    logic fu_reg, fu_next, fv_reg, fv_next;
    logic [IW-1:0] iu_reg, iu_next, iv_reg, iv_next;
    logic [CW-1:0] i_reg, i_next, nc_reg, nc_next;
    logic [ELIM_W-1:0] ec_reg, ec_next;
    logic [IW-1:0] u_reg, u_next, v_reg, v_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [IW-1:0] p_reg, p_next, x_reg, x_next, meet_reg, meet_next;
    logic dir_reg, dir_next, met_reg, met_next, ro_reg, ro_next;
    logic [N-1:0] fmask_reg, fmask_next, bmask_reg, bmask_next;
    logic [N-1:0] inwin_reg, inwin_next, cand_reg, cand_next;
    logic [CW-1:0] sp_reg, sp_next, nf_reg, nf_next, nb_reg, nb_next;
    logic [CW-1:0] c_reg, c_next, np_reg, np_next, k_reg, k_next;
    logic [VIS_W-1:0] vis_reg, vis_next;
    logic res_valid_reg, res_valid_next;
    res_t res_reg, res_next;

    // memories
    logic [KW-1:0] ids_mem [N];
    logic [IW-1:0] pos_mem [N], nap_mem [N], fpar_mem [N], bpar_mem [N];
    logic [IW-1:0] stk_mem [N], plist_mem [N], list_mem [N];

    logic [IW-1:0] ids_ra, pos_ra, stk_ra;
    logic [KW-1:0] ids_q;
    logic [IW-1:0] pos_q, nap_q, fpar_q, bpar_q, stk_q, plist_q, list_q;

    logic          ids_we, pos_we, nap_we, fpar_we, bpar_we, stk_we, plist_we, list_we;
    logic [IW-1:0] ids_wa, pos_wa, nap_wa, par_wa, stk_wa, plist_wa, list_wa;
    logic [KW-1:0] ids_wd;
    logic [IW-1:0] pos_wd, nap_wd, par_wd, stk_wd, plist_wd, list_wd;

    logic [IW-1:0] succ_ra, pred_ra;
    logic [N-1:0]  succ_q, pred_q, succ_wd, pred_wd;
    logic          succ_we, pred_we;

    logic [1:0]    nnew;
    logic [LW-1:0] cap;
    logic          edge_full;
    logic [VW-1:0] vsum;
    logic [N-1:0]  row_sel, mask_sel, cand_new;
    logic [IW-1:0] y_sel, s_sel;

    ito_rowmem #(.MAX_NODES(N)) u_succ (
        .clk(clk), .rst_n(rst_n), .ra(succ_ra), .q(succ_q),
        .we(succ_we), .wa(u_reg), .wd(succ_wd)
    );

    ito_rowmem #(.MAX_NODES(N)) u_pred (
        .clk(clk), .rst_n(rst_n), .ra(pred_ra), .q(pred_q),
        .we(pred_we), .wa(v_reg), .wd(pred_wd)
    );

    always_ff @(posedge clk)
    begin
        if (ids_we)   ids_mem[ids_wa]     <= ids_wd;
        if (pos_we)   pos_mem[pos_wa]     <= pos_wd;
        if (nap_we)   nap_mem[nap_wa]     <= nap_wd;
        if (fpar_we)  fpar_mem[par_wa]    <= par_wd;
        if (bpar_we)  bpar_mem[par_wa]    <= par_wd;
        if (stk_we)   stk_mem[stk_wa]     <= stk_wd;
        if (plist_we) plist_mem[plist_wa] <= plist_wd;
        if (list_we)  list_mem[list_wa]   <= list_wd;
        ids_q   <= ids_mem[ids_ra];
        pos_q   <= pos_mem[pos_ra];
        nap_q   <= nap_mem[p_reg];
        fpar_q  <= fpar_mem[x_reg];
        bpar_q  <= bpar_mem[x_reg];
        stk_q   <= stk_mem[stk_ra];
        plist_q <= plist_mem[i_reg[IW-1:0]];
        list_q  <= list_mem[i_reg[IW-1:0]];
    end

    always_comb
    begin
        nnew      = 2'(!fu_reg) + 2'(!fv_reg);
        cap       = (LW'(cfg.node_limit) < LW'(N)) ? LW'(cfg.node_limit) : LW'(N);
        edge_full = (13'(ec_reg) + 13'd1) > 13'(cfg.edge_limit);
        vsum      = VW'(nf_reg) + VW'(nb_reg);
        row_sel   = dir_reg ? succ_q : pred_q;
        mask_sel  = dir_reg ? fmask_reg : bmask_reg;
        cand_new  = row_sel & ~mask_sel & inwin_reg;
        y_sel     = lowest(cand_reg);
        s_sel     = dir_reg ? v_reg : u_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        rt_next = rt_reg; a_next = a_reg; b_next = b_reg;
        fu_next = fu_reg; fv_next = fv_reg; iu_next = iu_reg; iv_next = iv_reg;
        i_next = i_reg; nc_next = nc_reg; ec_next = ec_reg;
        u_next = u_reg; v_next = v_reg; lo_next = lo_reg; hi_next = hi_reg;
        p_next = p_reg; x_next = x_reg; meet_next = meet_reg;
        dir_next = dir_reg; met_next = met_reg; ro_next = ro_reg;
        fmask_next = fmask_reg; bmask_next = bmask_reg;
        inwin_next = inwin_reg; cand_next = cand_reg;
        sp_next = sp_reg; nf_next = nf_reg; nb_next = nb_reg;
        c_next = c_reg; np_next = np_reg; k_next = k_reg; vis_next = vis_reg;
        res_valid_next = 1'b0;
        res_next = res_reg;

        ids_ra = '0; pos_ra = '0; stk_ra = '0;
        succ_ra = stk_q; pred_ra = stk_q;
        ids_we = 1'b0; pos_we = 1'b0; nap_we = 1'b0; fpar_we = 1'b0; bpar_we = 1'b0;
        stk_we = 1'b0; plist_we = 1'b0; list_we = 1'b0;
        ids_wa = nc_reg[IW-1:0]; ids_wd = a_reg;
        pos_wa = nc_reg[IW-1:0]; pos_wd = nc_reg[IW-1:0];
        nap_wa = nc_reg[IW-1:0]; nap_wd = nc_reg[IW-1:0];
        par_wa = y_sel; par_wd = x_reg;
        stk_wa = sp_reg[IW-1:0]; stk_wd = y_sel;
        plist_wa = np_reg[IW-1:0]; plist_wd = p_reg;
        list_wa = k_reg[IW-1:0]; list_wd = nap_q;
        succ_we = 1'b0; pred_we = 1'b0;
        succ_wd = succ_q | (N'(1) << v_reg);
        pred_wd = pred_q | (N'(1) << u_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rt_next = req_type;
                    a_next  = src_id[KW-1:0];
                    b_next  = dst_id[KW-1:0];
                    fu_next = 1'b0;
                    fv_next = 1'b0;
                    i_next  = '0;
                    if (req_type != REQ_ADD_NODE && src_id[KW-1:0] == dst_id[KW-1:0])
                    begin
                        res_valid_next = 1'b1;
                        res_next = mk(ST_CYCLE, 1'b0, '0, src_id[KW-1:0], 1'b1);
                    end
                    else
                    begin
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                ids_ra = i_reg[IW-1:0];
                state_next = (i_reg == nc_reg) ? S_DECIDE : S_LOOKC;
            end
            S_LOOKC:
            begin
                if (ids_q == a_reg)
                begin
                    fu_next = 1'b1;
                    iu_next = i_reg[IW-1:0];
                end
                if (ids_q == b_reg)
                begin
                    fv_next = 1'b1;
                    iv_next = i_reg[IW-1:0];
                end
                i_next = i_reg + 1'b1;
                state_next = S_LOOK;
            end
            S_DECIDE:
            begin
                succ_ra = iu_reg;
                if (rt_reg == REQ_ADD_NODE)
                begin
                    res_valid_next = 1'b1;
                    state_next = S_IDLE;
                    if (fu_reg)
                    begin
                        res_next = mk(ST_EXISTS, 1'b0, '0, '0, 1'b1);
                    end
                    else if (nc_reg >= CW'(N))
                    begin
                        res_next = mk(ST_FULL, 1'b0, '0, '0, 1'b1);
                    end
                    else
                    begin
                        ids_we = 1'b1; pos_we = 1'b1; nap_we = 1'b1;
                        nc_next = nc_reg + 1'b1;
                        res_next = mk(ST_OK, 1'b0, '0, '0, 1'b1);
                    end
                end
                else
                begin
                    state_next = (fu_reg && fv_reg) ? S_DUP : S_LIM;
                end
            end
            S_DUP:
            begin
                if (succ_q[iv_reg])
                begin
                    res_valid_next = 1'b1;
                    res_next = mk(ST_DUP, 1'b0, '0, '0, 1'b1);
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_LIM;
                end
            end
            S_LIM:
            begin
                if (LW'(nc_reg) + LW'(nnew) > cap)
                begin
                    res_valid_next = 1'b1;
                    res_next = mk(ST_NODE_LIM, 1'b0, '0, '0, 1'b1);
                    state_next = S_IDLE;
                end
                else if (nnew != 2'd0 && edge_full)
                begin
                    res_valid_next = 1'b1;
                    res_next = mk(ST_EDGE_LIM, 1'b0, '0, '0, 1'b1);
                    state_next = S_IDLE;
                end
                else
                begin
                    u_next = iu_reg;
                    if (!fu_reg)
                    begin
                        ids_we = 1'b1; pos_we = 1'b1; nap_we = 1'b1;
                        u_next = nc_reg[IW-1:0];
                        nc_next = nc_reg + 1'b1;
                    end
                    state_next = S_INTV;
                end
            end
            S_INTV:
            begin
                v_next = iv_reg;
                ids_wd = b_reg;
                if (!fv_reg)
                begin
                    ids_we = 1'b1; pos_we = 1'b1; nap_we = 1'b1;
                    v_next = nc_reg[IW-1:0];
                    nc_next = nc_reg + 1'b1;
                end
                state_next = S_PU;
            end
            S_PU:
            begin
                pos_ra = u_reg;
                state_next = S_PV;
            end
            S_PV:
            begin
                hi_next = pos_q;
                pos_ra = v_reg;
                state_next = S_PCMP;
            end
            S_PCMP:
            begin
                ro_next  = 1'b0;
                vis_next = '0;
                if (hi_reg < pos_q)
                begin
                    if (edge_full)
                    begin
                        res_valid_next = 1'b1;
                        res_next = mk(ST_EDGE_LIM, 1'b0, '0, '0, 1'b1);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ADD0;
                    end
                end
                else
                begin
                    lo_next = pos_q;
                    p_next  = pos_q;
                    inwin_next = '0;
                    fmask_next = '0;
                    bmask_next = '0;
                    met_next = 1'b0;
                    dir_next = 1'b0;
                    state_next = S_WIN;
                end
            end
            S_WIN:
            begin
                state_next = S_WINC;
            end
            S_WINC:
            begin
                inwin_next[nap_q] = 1'b1;
                if (p_reg == hi_reg)
                begin
                    state_next = S_SINIT;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                    state_next = S_WIN;
                end
            end
            // backward search from u first, then forward from v checking for a meet
            S_SINIT:
            begin
                par_wa = s_sel;
                par_wd = s_sel;
                stk_wa = '0;
                stk_wd = s_sel;
                stk_we = 1'b1;
                sp_next = CW'(1);
                if (dir_reg)
                begin
                    fmask_next[s_sel] = 1'b1;
                    fpar_we = 1'b1;
                    nf_next = CW'(1);
                    if (bmask_reg[s_sel])
                    begin
                        met_next  = 1'b1;
                        meet_next = s_sel;
                    end
                end
                else
                begin
                    bmask_next[s_sel] = 1'b1;
                    bpar_we = 1'b1;
                    nb_next = CW'(1);
                end
                state_next = S_POP;
            end
            S_POP:
            begin
                stk_ra = sp_reg[IW-1:0] - 1'b1;
                if (sp_reg == '0)
                begin
                    if (dir_reg)
                    begin
                        state_next = S_AFTER;
                    end
                    else
                    begin
                        dir_next = 1'b1;
                        state_next = S_SINIT;
                    end
                end
                else
                begin
                    sp_next = sp_reg - 1'b1;
                    state_next = S_POPW;
                end
            end
            S_POPW:
            begin
                x_next = stk_q;
                state_next = S_ROW;
            end
            S_ROW:
            begin
                cand_next = cand_new;
                if (dir_reg)
                begin
                    fmask_next = fmask_reg | cand_new;
                end
                else
                begin
                    bmask_next = bmask_reg | cand_new;
                end
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (cand_reg == '0)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    stk_we = 1'b1;
                    sp_next = sp_reg + 1'b1;
                    cand_next[y_sel] = 1'b0;
                    if (dir_reg)
                    begin
                        fpar_we = 1'b1;
                        nf_next = nf_reg + 1'b1;
                        if (!met_reg && bmask_reg[y_sel])
                        begin
                            met_next  = 1'b1;
                            meet_next = y_sel;
                        end
                    end
                    else
                    begin
                        bpar_we = 1'b1;
                        nb_next = nb_reg + 1'b1;
                    end
                end
            end
            S_AFTER:
            begin
                vis_next = (vsum > VW'(255)) ? 8'hFF : vsum[7:0];
                if (met_reg)
                begin
                    x_next = meet_reg;
                    c_next = '0;
                    state_next = S_CH;
                end
                else if (edge_full)
                begin
                    res_valid_next = 1'b1;
                    res_next = mk(ST_EDGE_LIM, 1'b0,
                                  (vsum > VW'(255)) ? 8'hFF : vsum[7:0], '0, 1'b1);
                    state_next = S_IDLE;
                end
                else
                begin
                    p_next  = lo_reg;
                    np_next = '0;
                    k_next  = '0;
                    state_next = S_RA1;
                end
            end
            // forward parent chain meet..v, kept on the stack for reversed output
            S_CH:
            begin
                stk_we = 1'b1;
                stk_wa = c_reg[IW-1:0];
                stk_wd = x_reg;
                c_next = c_reg + 1'b1;
                state_next = (x_reg == v_reg) ? S_OUTC : S_CHW;
            end
            S_CHW:
            begin
                x_next = fpar_q;
                state_next = S_CH;
            end
            S_OUTC:
            begin
                c_next = c_reg - 1'b1;
                stk_ra = c_reg[IW-1:0] - 1'b1;
                state_next = S_OUTCW;
            end
            S_OUTCW:
            begin
                ids_ra = stk_q;
                state_next = S_OUTCE;
            end
            S_OUTCE:
            begin
                res_valid_next = 1'b1;
                res_next = mk(ST_CYCLE, 1'b0, vis_reg, ids_q,
                              c_reg == '0 && meet_reg == u_reg);
                if (c_reg != '0)
                begin
                    state_next = S_OUTC;
                end
                else if (meet_reg == u_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    x_next = meet_reg;
                    state_next = S_BK;
                end
            end
            S_BK:
            begin
                state_next = S_BKW;
            end
            S_BKW:
            begin
                x_next = bpar_q;
                ids_ra = bpar_q;
                state_next = S_BKE;
            end
            S_BKE:
            begin
                res_valid_next = 1'b1;
                res_next = mk(ST_CYCLE, 1'b0, vis_reg, ids_q, x_reg == u_reg);
                state_next = (x_reg == u_reg) ? S_IDLE : S_BK;
            end
            // reorder: window positions held by either set, backward nodes first
            S_RA1:
            begin
                state_next = S_RA2;
            end
            S_RA2:
            begin
                if (bmask_reg[nap_q] || fmask_reg[nap_q])
                begin
                    plist_we = 1'b1;
                    np_next = np_reg + 1'b1;
                end
                if (bmask_reg[nap_q])
                begin
                    list_we = 1'b1;
                    k_next = k_reg + 1'b1;
                end
                if (p_reg == hi_reg)
                begin
                    p_next = lo_reg;
                    state_next = S_RB1;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                    state_next = S_RA1;
                end
            end
            S_RB1:
            begin
                state_next = S_RB2;
            end
            S_RB2:
            begin
                if (fmask_reg[nap_q] && !bmask_reg[nap_q])
                begin
                    list_we = 1'b1;
                    k_next = k_reg + 1'b1;
                end
                if (p_reg == hi_reg)
                begin
                    i_next = '0;
                    state_next = S_RC1;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                    state_next = S_RB1;
                end
            end
            S_RC1:
            begin
                if (i_reg == np_reg)
                begin
                    ro_next = 1'b1;
                    state_next = S_ADD0;
                end
                else
                begin
                    state_next = S_RC2;
                end
            end
            S_RC2:
            begin
                nap_we = 1'b1;
                nap_wa = plist_q;
                nap_wd = list_q;
                pos_we = 1'b1;
                pos_wa = list_q;
                pos_wd = plist_q;
                i_next = i_reg + 1'b1;
                state_next = S_RC1;
            end
            S_ADD0:
            begin
                succ_ra = u_reg;
                pred_ra = v_reg;
                state_next = S_ADD1;
            end
            S_ADD1:
            begin
                succ_we = 1'b1;
                pred_we = 1'b1;
                ec_next = ec_reg + 1'b1;
                res_valid_next = 1'b1;
                res_next = mk(ST_OK, ro_reg, vis_reg, '0, 1'b1);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nc_reg        <= '0;
            ec_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nc_reg        <= nc_next;
            ec_reg        <= ec_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rt_reg <= rt_next; a_reg <= a_next; b_reg <= b_next;
        fu_reg <= fu_next; fv_reg <= fv_next; iu_reg <= iu_next; iv_reg <= iv_next;
        i_reg <= i_next; u_reg <= u_next; v_reg <= v_next;
        lo_reg <= lo_next; hi_reg <= hi_next; p_reg <= p_next; x_reg <= x_next;
        meet_reg <= meet_next; dir_reg <= dir_next; met_reg <= met_next; ro_reg <= ro_next;
        fmask_reg <= fmask_next; bmask_reg <= bmask_next;
        inwin_reg <= inwin_next; cand_reg <= cand_next;
        sp_reg <= sp_next; nf_reg <= nf_next; nb_reg <= nb_next;
        c_reg <= c_next; np_reg <= np_next; k_reg <= k_next; vis_reg <= vis_next;
        res_reg <= res_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/incremental_topological_order_unit.sv
// incremental_topological_order_unit: top level, configuration registers and core
// depends on ito_pkg, ito_core
//
// channel   | signals                                   | handshake
// ----------+-------------------------------------------+------------------------------
// request   | req_type, src_id, dst_id                  | start high while busy low
// result    | status, reordered, visited, path_id, last | result_valid, one cycle each
// config    | cfg_we, cfg_index, cfg_wdata              | write when cfg_we high
//
// add node: the id table is scanned over the n stored nodes, then the new id is appended.
// edge insert: the same id scan, then for a search a pass over the window positions and a
// walk per visited node, and for the reorder two window passes and a write-back of positions.
// a cycle result streams its path ids one at a time; busy falls as the last one is presented.
// rst_n clears node and edge counts and adjacency rows and sets config registers to defaults;
// results cannot be held off by the receiver.
`default_nettype none

module incremental_topological_order_unit
    import ito_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int ID_WIDTH  = ID_WIDTH_DEF
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  req_type,
    input  wire logic signed [31:0]    src_id,
    input  wire logic signed [31:0]    dst_id,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                       result_valid,
    output logic [2:0]                 status,
    output logic                       reordered,
    output logic [VIS_W-1:0]           visited,
    output logic signed [31:0]         path_id,
    output logic                       last
);

    cfg_t cfg_reg;
    res_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_limit <= NLIM_W'(64);
            cfg_reg.edge_limit <= ELIM_W'(4032);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NODE_LIMIT: cfg_reg.node_limit <= cfg_wdata[NLIM_W-1:0];
                CFG_EDGE_LIMIT: cfg_reg.edge_limit <= cfg_wdata[ELIM_W-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    ito_core #(
        .MAX_NODES(MAX_NODES),
        .ID_WIDTH (ID_WIDTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .src_id   (src_id),
        .dst_id   (dst_id),
        .cfg      (cfg_reg),
        .busy     (busy),
        .res_valid(result_valid),
        .res      (res)
    );

    assign status    = res.status;
    assign reordered = res.reordered;
    assign visited   = res.visited;
    assign path_id   = res.path_id;
    assign last      = res.last;

endmodule

`default_nettype wire
